/* sv/cam_pkg.sv */
// Shared types, constants and coefficient tables for the chromatic adaptation matrix core.
package cam_pkg;

    localparam int AW         = 84;
    localparam int BW         = 60;
    localparam int QW         = 41;
    localparam int WW         = 42;
    localparam int CW         = 62;
    localparam int RW         = 34;
    localparam int KW         = 32;
    localparam int PW         = 66;
    localparam int SW         = 68;
    localparam int RATIO_FRAC = 24;
    localparam int KQ_FRAC    = 28;
    localparam int QDEPTH     = 2;
    localparam int KENTRIES   = 81;

    localparam longint FIVE_POW12 = 64'sd244140625;

    localparam logic signed [31:0] COEF_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] COEF_MIN = 32'sh80000000;

    localparam int CONE_FWD [3][3][3] = '{
        '{'{100000, 0, 0}, '{0, 100000, 0}, '{0, 0, 100000}},
        '{'{89510, 26640, -16140}, '{-75020, 171350, 3670}, '{3890, -6850, 102960}},
        '{'{40024, 70760, -8081}, '{-22630, 116532, 4570}, '{0, 0, 91822}}
    };

    localparam int CONE_INV [3][3][3] = '{
        '{'{10000000, 0, 0}, '{0, 10000000, 0}, '{0, 0, 10000000}},
        '{'{9869929, -1470543, 1599627}, '{4323053, 5183603, 492912},
          '{-85287, 400428, 9684867}},
        '{'{18599364, -11293816, 2198974}, '{3611914, 6388125, -64},
          '{0, 0, 10890636}}
    };

    typedef logic [KENTRIES-1:0][KW-1:0] ktab_t;

    function automatic ktab_t build_ktab();
        ktab_t  tab;
        longint t;
        longint a;
        longint r;
        tab = '0;
        for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    for (int k = 0; k < 3; k++) begin
                        t = longint'(CONE_INV[m][j][i]) * longint'(CONE_FWD[m][i][k]);
                        a = (t < 0) ? -t : t;
                        r = ((a <<< 17) + FIVE_POW12) / (2 * FIVE_POW12);
                        tab[m * 27 + j * 9 + i * 3 + k] = KW'((t < 0) ? -r : r);
                    end
                end
            end
        end
        return tab;
    endfunction

    localparam ktab_t KTAB = build_ktab();

    typedef struct packed {
        logic [1:0]  adapt_mode;
        logic [23:0] src_lum;
        logic [15:0] src_cx;
        logic [15:0] src_cy;
        logic [23:0] dst_lum;
        logic [15:0] dst_cx;
        logic [15:0] dst_cy;
    } cam_in_t;

    typedef struct packed {
        logic [1:0]         entry_row;
        logic [1:0]         entry_col;
        logic signed [31:0] coefficient;
        logic               saturated;
        logic               status;
        logic               last;
    } cam_out_t;

    typedef struct packed {
        logic                  status;
        logic                  diag;
        logic [1:0]            midx;
        logic [2:0][RW-1:0]    ratio;
    } cam_job_t;

    typedef struct packed {
        logic          done;
        logic          ovf;
        logic [QW-1:0] quo;
    } cam_div_rsp_t;

endpackage

/* sv/cam_div.sv */
// Shared restoring divider, one quotient bit per cycle, with overflow detect.
module cam_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cam_pkg::AW-1:0]    num,
    input  logic [cam_pkg::BW-1:0]    den,
    output cam_pkg::cam_div_rsp_t     rsp
);
    import cam_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [BW-1:0]     den_reg, den_next;
    logic [QW-1:0]     sh_reg, sh_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [BW:0]       trial;
    logic              too_big;

    assign too_big = {{(BW + QW - AW){1'b0}}, num} >= {den, {QW{1'b0}}};
    assign trial   = {rem_reg, sh_reg[QW-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        quo_next  = quo_reg;
        if (start) begin
            den_next = den;
            quo_next = '0;
            sh_next  = num[QW-1:0];
            rem_next = {{(BW - (AW - QW)){1'b0}}, num[AW-1:QW]};
            cnt_next = 7'(QW);
            ovf_next = too_big;
            if (too_big) begin
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = BW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = trial[BW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            sh_next  = {sh_reg[QW-2:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* sv/cam_front.sv */
// Front end: input buffer, white point to XYZ, cone responses and ratio division.
module cam_front #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cam_pkg::cam_in_t   s_data,
    output logic               job_push,
    output cam_pkg::cam_job_t  job_data,
    input  logic               job_full
);
    import cam_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_XMUL = 7'b0000010,
        ST_XDIV = 7'b0000100,
        ST_MAC  = 7'b0001000,
        ST_RMUL = 7'b0010000,
        ST_RDIV = 7'b0100000,
        ST_PUSH = 7'b1000000
    } fst_t;

    localparam logic [QW-1:0] RCAP = {{(QW - 33){1'b0}}, 1'b1, 32'b0};
    localparam logic [QW-1:0] DCAP = {{(QW - 34){1'b0}}, 1'b1, 33'b0};

    fst_t                 state_reg, state_next;
    cam_in_t              buf_reg;
    logic                 buf_valid_reg;
    logic                 take;
    cam_in_t              itm_reg, itm_next;
    logic                 stat_reg, stat_next;
    logic [1:0]           xi_reg, xi_next;
    logic [1:0]           ri_reg, ri_next;
    logic                 ms_reg, ms_next;
    logic [1:0]           mc_reg, mc_next;
    logic [1:0]           mk_reg, mk_next;
    logic                 neg_reg, neg_next;
    logic                 start_reg, start_next;
    logic [AW-1:0]        a_reg, a_next;
    logic [BW-1:0]        b_reg, b_next;
    logic signed [WW-1:0] w_reg [2][3];
    logic signed [WW-1:0] w_next [2][3];
    logic signed [CW-1:0] c_reg [2][3];
    logic signed [CW-1:0] c_next [2][3];
    logic signed [RW-1:0] r_reg [3];
    logic signed [RW-1:0] r_next [3];
    cam_div_rsp_t         div_rsp;

    logic [1:0]           midx;
    logic                 side;
    logic [23:0]          lum;
    logic [15:0]          cx;
    logic [15:0]          cy;
    logic signed [18:0]   zc;
    logic [16:0]          zmag;
    logic [40:0]          xprod;
    logic signed [18:0]   mcoef;
    logic signed [60:0]   mprod;
    logic signed [CW-1:0] cs;
    logic signed [CW-1:0] cd;
    logic [BW-1:0]        cs_mag;
    logic [BW-1:0]        cd_mag;
    logic [QW-1:0]        qr;
    logic [QW-1:0]        qd;
    logic [QW-1:0]        vd;
    logic signed [WW-1:0] wq;

    assign s_ready = !buf_valid_reg;
    assign take    = (state_reg == ST_IDLE) && buf_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            buf_valid_reg <= 1'b1;
        end else if (take) begin
            buf_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            buf_reg <= s_data;
        end
    end

    cam_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .num     (a_reg),
        .den     (b_reg),
        .rsp     (div_rsp)
    );

    assign midx   = itm_reg.adapt_mode - 2'd1;
    assign side   = xi_reg[1];
    assign lum    = side ? itm_reg.dst_lum : itm_reg.src_lum;
    assign cx     = side ? itm_reg.dst_cx : itm_reg.src_cx;
    assign cy     = side ? itm_reg.dst_cy : itm_reg.src_cy;
    assign zc     = $signed(19'd65536) - $signed({3'b0, cx}) - $signed({3'b0, cy});
    assign zmag   = zc[18] ? 17'(-zc) : 17'(zc);
    assign xprod  = (xi_reg[0] ? 41'(zmag) : 41'(cx)) * 41'(lum);
    assign mcoef  = 19'(CONE_FWD[midx][mc_reg][mk_reg]);
    assign mprod  = 61'(mcoef) * 61'(w_reg[ms_reg][mk_reg]);
    assign cs     = c_reg[0][ri_reg];
    assign cd     = c_reg[1][ri_reg];
    assign cs_mag = BW'(cs[CW-1] ? -cs : cs);
    assign cd_mag = BW'(cd[CW-1] ? -cd : cd);
    assign qr     = (div_rsp.ovf || div_rsp.quo > RCAP) ? RCAP : div_rsp.quo;
    assign qd     = (div_rsp.ovf || div_rsp.quo > DCAP) ? DCAP : div_rsp.quo;
    assign vd     = (qd + QW'(1)) >> 1;
    assign wq     = neg_reg ? -WW'(div_rsp.quo) : WW'(div_rsp.quo);

    always_comb begin
        state_next = state_reg;
        itm_next   = itm_reg;
        stat_next  = stat_reg;
        xi_next    = xi_reg;
        ri_next    = ri_reg;
        ms_next    = ms_reg;
        mc_next    = mc_reg;
        mk_next    = mk_reg;
        neg_next   = neg_reg;
        start_next = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        w_next     = w_reg;
        c_next     = c_reg;
        r_next     = r_reg;
        job_push   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (buf_valid_reg) begin
                    itm_next  = buf_reg;
                    stat_next = 1'b0;
                    xi_next   = '0;
                    ri_next   = '0;
                    for (int s = 0; s < 2; s++) begin
                        for (int i = 0; i < 3; i++) begin
                            c_next[s][i] = '0;
                        end
                    end
                    w_next[0][1] = WW'(buf_reg.src_lum);
                    w_next[1][1] = WW'(buf_reg.dst_lum);
                    if (buf_reg.adapt_mode == 2'd0) begin
                        if (buf_reg.src_lum == '0) begin
                            stat_next  = 1'b1;
                            state_next = ST_PUSH;
                        end else begin
                            a_next     = AW'(buf_reg.dst_lum) << (COEF_FRAC_BITS + 1);
                            b_next     = BW'(buf_reg.src_lum);
                            start_next = 1'b1;
                            state_next = ST_RDIV;
                        end
                    end else if (buf_reg.src_cy == '0 || buf_reg.dst_cy == '0 ||
                                 buf_reg.src_lum == '0) begin
                        stat_next  = 1'b1;
                        state_next = ST_PUSH;
                    end else begin
                        state_next = ST_XMUL;
                    end
                end
            end
            ST_XMUL: begin
                a_next     = AW'(xprod);
                b_next     = BW'(cy);
                neg_next   = xi_reg[0] & zc[18];
                start_next = 1'b1;
                state_next = ST_XDIV;
            end
            ST_XDIV: begin
                if (div_rsp.done) begin
                    w_next[side][xi_reg[0] ? 2 : 0] = wq;
                    if (xi_reg == 2'd3) begin
                        ms_next    = 1'b0;
                        mc_next    = '0;
                        mk_next    = '0;
                        state_next = ST_MAC;
                    end else begin
                        xi_next    = xi_reg + 2'd1;
                        state_next = ST_XMUL;
                    end
                end
            end
            ST_MAC: begin
                c_next[ms_reg][mc_reg] = c_reg[ms_reg][mc_reg] + CW'(mprod);
                if (mk_reg == 2'd2) begin
                    mk_next = '0;
                    if (mc_reg == 2'd2) begin
                        mc_next = '0;
                        if (ms_reg) begin
                            ri_next    = '0;
                            state_next = ST_RMUL;
                        end else begin
                            ms_next = 1'b1;
                        end
                    end else begin
                        mc_next = mc_reg + 2'd1;
                    end
                end else begin
                    mk_next = mk_reg + 2'd1;
                end
            end
            ST_RMUL: begin
                if (ri_reg == 2'd0 &&
                    (c_reg[0][0] == '0 || c_reg[0][1] == '0 || c_reg[0][2] == '0)) begin
                    stat_next  = 1'b1;
                    state_next = ST_PUSH;
                end else begin
                    a_next     = AW'(cd_mag) << RATIO_FRAC;
                    b_next     = cs_mag;
                    neg_next   = cs[CW-1] ^ cd[CW-1];
                    start_next = 1'b1;
                    state_next = ST_RDIV;
                end
            end
            ST_RDIV: begin
                if (div_rsp.done) begin
                    if (itm_reg.adapt_mode == 2'd0) begin
                        r_next[0]  = RW'(vd);
                        state_next = ST_PUSH;
                    end else begin
                        r_next[ri_reg] = neg_reg ? -RW'(qr) : RW'(qr);
                        if (ri_reg == 2'd2) begin
                            state_next = ST_PUSH;
                        end else begin
                            ri_next    = ri_reg + 2'd1;
                            state_next = ST_RMUL;
                        end
                    end
                end
            end
            ST_PUSH: begin
                if (!job_full) begin
                    job_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
        itm_reg <= itm_next;
        stat_reg <= stat_next;
        xi_reg  <= xi_next;
        ri_reg  <= ri_next;
        ms_reg  <= ms_next;
        mc_reg  <= mc_next;
        mk_reg  <= mk_next;
        neg_reg <= neg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        w_reg   <= w_next;
        c_reg   <= c_next;
        r_reg   <= r_next;
    end

    assign job_data.status   = stat_reg;
    assign job_data.diag     = (itm_reg.adapt_mode == 2'd0);
    assign job_data.midx     = midx;
    assign job_data.ratio[0] = r_reg[0];
    assign job_data.ratio[1] = r_reg[1];
    assign job_data.ratio[2] = r_reg[2];

endmodule

/* sv/cam_queue.sv */
// Two-entry job queue between front and back end.
module cam_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cam_pkg::cam_job_t  push_data,
    output logic               full,
    input  logic               pop,
    output cam_pkg::cam_job_t  pop_data,
    output logic               empty
);
    import cam_pkg::*;

    cam_job_t   mem_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'(QDEPTH));
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/cam_back.sv */
// Back end: matrix product or diagonal ratio per coefficient, rounding, saturation and output register.
module cam_back #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    input  cam_pkg::cam_job_t  job_data,
    output logic               job_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output cam_pkg::cam_out_t  m_data
);
    import cam_pkg::*;

    localparam int SH = RATIO_FRAC + KQ_FRAC - COEF_FRAC_BITS;

    logic                 adv;
    logic                 issue;
    logic                 last_n;
    logic [1:0]           row_reg;
    logic [1:0]           col_reg;
    logic                 p_valid_reg;
    logic [1:0]           p_row_reg;
    logic [1:0]           p_col_reg;
    logic                 p_last_reg;
    logic                 p_status_reg;
    logic                 p_diag_reg;
    logic [RW-1:0]        p_dv_reg;
    logic signed [PW-1:0] p_prod_reg [3];
    logic signed [PW-1:0] prod [3];
    logic [6:0]           kidx [3];
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] rnd;
    logic signed [SW-1:0] shv;
    logic signed [31:0]   mat_coef;
    logic                 mat_sat;
    logic signed [31:0]   coef;
    logic                 sat;
    logic                 m_valid_reg;
    cam_out_t             m_data_reg;

    assign adv    = !m_valid_reg || m_ready;
    assign issue  = job_valid && adv;
    assign last_n = (row_reg == 2'd2) && (col_reg == 2'd2);
    assign job_pop = issue && last_n;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            kidx[i] = 7'(int'(job_data.midx) * 27 + int'(row_reg) * 9 + i * 3 +
                      int'(col_reg));
            prod[i] = PW'($signed(KTAB[kidx[i]])) * PW'($signed(job_data.ratio[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            p_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= issue;
            if (issue) begin
                if (col_reg == 2'd2) begin
                    col_reg <= '0;
                    row_reg <= last_n ? 2'd0 : row_reg + 2'd1;
                end else begin
                    col_reg <= col_reg + 2'd1;
                end
            end
        end
        if (issue) begin
            p_row_reg    <= row_reg;
            p_col_reg    <= col_reg;
            p_last_reg   <= last_n;
            p_status_reg <= job_data.status;
            p_diag_reg   <= job_data.diag;
            p_dv_reg     <= job_data.ratio[0];
            p_prod_reg   <= prod;
        end
    end

    assign sum = SW'(p_prod_reg[0]) + SW'(p_prod_reg[1]) + SW'(p_prod_reg[2]);
    assign rnd = sum + (SW'(1) <<< (SH - 1));
    assign shv = rnd >>> SH;

    always_comb begin
        if (shv > SW'(COEF_MAX)) begin
            mat_coef = COEF_MAX;
            mat_sat  = 1'b1;
        end else if (shv < SW'(COEF_MIN)) begin
            mat_coef = COEF_MIN;
            mat_sat  = 1'b1;
        end else begin
            mat_coef = 32'(shv);
            mat_sat  = 1'b0;
        end
        if (p_status_reg) begin
            coef = '0;
            sat  = 1'b0;
        end else if (p_diag_reg) begin
            if (p_row_reg != p_col_reg) begin
                coef = '0;
                sat  = 1'b0;
            end else if (p_dv_reg > RW'(COEF_MAX)) begin
                coef = COEF_MAX;
                sat  = 1'b1;
            end else begin
                coef = 32'(p_dv_reg);
                sat  = 1'b0;
            end
        end else begin
            coef = mat_coef;
            sat  = mat_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= p_valid_reg;
        end
        if (adv && p_valid_reg) begin
            m_data_reg.entry_row   <= p_row_reg;
            m_data_reg.entry_col   <= p_col_reg;
            m_data_reg.coefficient <= coef;
            m_data_reg.saturated   <= sat;
            m_data_reg.status      <= p_status_reg;
            m_data_reg.last        <= p_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.status |->
            m_data_reg.coefficient == '0 && !m_data_reg.saturated)
        else $error("invalid white point with nonzero coefficient");

    a_pop_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> row_reg == 2'd2 && col_reg == 2'd2)
        else $error("job released before its ninth coefficient");

    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && p_last_reg |-> p_row_reg == 2'd2 && p_col_reg == 2'd2)
        else $error("last flag on wrong entry");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && !adv |=> p_valid_reg && $stable(p_row_reg) && $stable(p_col_reg))
        else $error("product stage lost an entry during stall");

endmodule

/* sv/chromatic_adaptation_matrix_core.sv */
// Matrix modes: seven divides from input transfer to first result, each after its own
// set-up state on the shared one-bit-per-cycle divider, plus a cone MAC over both white
// points. Mode none: one divide; an item rejected on entry skips the divider entirely.
// Each item gives nine result transfers at one per cycle while m_ready is high; the divider
// sets the item rate.
// A two-entry job queue lets the front end work on the next item while results drain.
// Reset clears the handshake, sequencer and queue state; there is no clearing pass.
module chromatic_adaptation_matrix_core #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cam_pkg::cam_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cam_pkg::cam_out_t   m_data
);
    import cam_pkg::*;

    logic     job_push;
    cam_job_t job_in;
    logic     job_full;
    logic     job_pop;
    cam_job_t job_out;
    logic     job_empty;

    cam_front #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .job_push (job_push),
        .job_data (job_in),
        .job_full (job_full)
    );

    cam_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    cam_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!job_empty),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* verif/tb_chromatic_adaptation_matrix_core.sv */
// Self-checking bench for the chromatic adaptation matrix core: predicts all nine coefficients.
module tb_chromatic_adaptation_matrix_core;
    import cam_pkg::*;

    localparam int FRAC = 24;
    localparam longint LIMIT = 3000000;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0, MODE_XYZ = 2'd1, MODE_BRADFORD = 2'd2, MODE_VON_KRIES = 2'd3
    } adapt_mode_e;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cam_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    cam_out_t m_data;

    cam_in_t  pending_items[$];
    cam_out_t coef_expected[$];
    int errors = 0;
    int items_sent = 0;
    int coefs_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_send = 1'b0;
    longint cycles = 0;

    chromatic_adaptation_matrix_core #(.COEF_FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint fwd_coef(int m, int i, int k);
        longint t[27];
        t = '{100000, 0, 0, 0, 100000, 0, 0, 0, 100000,
              89510, 26640, -16140, -75020, 171350, 3670, 3890, -6850, 102960,
              40024, 70760, -8081, -22630, 116532, 4570, 0, 0, 91822};
        return t[m * 9 + i * 3 + k];
    endfunction

    function automatic longint inv_coef(int m, int j, int i);
        longint t[27];
        t = '{10000000, 0, 0, 0, 10000000, 0, 0, 0, 10000000,
              9869929, -1470543, 1599627, 4323053, 5183603, 492912, -85287, 400428, 9684867,
              18599364, -11293816, 2198974, 3611914, 6388125, -64, 0, 0, 10890636};
        return t[m * 9 + j * 3 + i];
    endfunction

    function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b, int f,
                                                    logic [63:0] cap);
        logic [63:0] q;
        logic [63:0] rem;
        q = a / b;
        rem = a % b;
        if (q > (cap >> f)) return cap;
        for (int i = 0; i < f; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= b) begin
                rem = rem - b;
                q[0] = 1'b1;
            end
        end
        return (q > cap) ? cap : q;
    endfunction

    function automatic longint clip32(longint v, output logic sat);
        sat = 1'b0;
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint kq28(int m, int j, int i, int k);
        longint t;
        longint a;
        longint r;
        t = inv_coef(m, j, i) * fwd_coef(m, i, k);
        a = (t < 0) ? -t : t;
        r = ((a <<< 17) + 64'sd244140625) / 64'sd488281250;
        return (t < 0) ? -r : r;
    endfunction

    task automatic predict_matrix(input cam_in_t it);
        longint coef[9];
        logic sat[9];
        logic status;
        longint ws[3], wd[3], cs[3], cd[3], r[3];
        longint acc, v;
        logic [63:0] q;
        logic s;
        int m;
        cam_out_t o;
        status = 1'b0;
        for (int n = 0; n < 9; n++) begin
            coef[n] = 0;
            sat[n] = 1'b0;
        end
        if (it.adapt_mode == MODE_NONE) begin
            if (it.src_lum == 0) begin
                status = 1'b1;
            end else begin
                q = scaled_quotient(64'(it.dst_lum), 64'(it.src_lum), FRAC + 1, 64'd1 << 33);
                v = clip32(longint'((q + 64'd1) >> 1), s);
                for (int n = 0; n < 3; n++) begin
                    coef[n * 4] = v;
                    sat[n * 4] = s;
                end
            end
        end else if (it.src_cy == 0 || it.dst_cy == 0 || it.src_lum == 0) begin
            status = 1'b1;
        end else begin
            m = int'(it.adapt_mode) - 1;
            ws[0] = longint'((64'(it.src_cx) * 64'(it.src_lum)) / 64'(it.src_cy));
            ws[1] = longint'(it.src_lum);
            ws[2] = (65536 - longint'(it.src_cx) - longint'(it.src_cy)) * longint'(it.src_lum)
                    / longint'(it.src_cy);
            wd[0] = longint'((64'(it.dst_cx) * 64'(it.dst_lum)) / 64'(it.dst_cy));
            wd[1] = longint'(it.dst_lum);
            wd[2] = (65536 - longint'(it.dst_cx) - longint'(it.dst_cy)) * longint'(it.dst_lum)
                    / longint'(it.dst_cy);
            for (int i = 0; i < 3; i++) begin
                cs[i] = 0;
                cd[i] = 0;
                for (int k = 0; k < 3; k++) begin
                    cs[i] += fwd_coef(m, i, k) * ws[k];
                    cd[i] += fwd_coef(m, i, k) * wd[k];
                end
                if (cs[i] == 0) status = 1'b1;
            end
            if (!status) begin
                for (int i = 0; i < 3; i++) begin
                    q = 0;
                    if (cd[i] != 0)
                        q = scaled_quotient((cd[i] < 0) ? -cd[i] : cd[i],
                                            (cs[i] < 0) ? -cs[i] : cs[i], 24, 64'd1 << 32);
                    r[i] = ((cd[i] < 0) != (cs[i] < 0)) ? -longint'(q) : longint'(q);
                end
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        acc = 0;
                        for (int i = 0; i < 3; i++) acc += kq28(m, j, i, k) * r[i];
                        acc = (acc + (64'sd1 <<< (51 - FRAC))) >>> (52 - FRAC);
                        coef[j * 3 + k] = clip32(acc, s);
                        sat[j * 3 + k] = s;
                    end
                end
            end
        end
        for (int n = 0; n < 9; n++) begin
            o.entry_row = 2'(n / 3);
            o.entry_col = 2'(n % 3);
            o.coefficient = status ? 32'sd0 : 32'(coef[n]);
            o.saturated = status ? 1'b0 : sat[n];
            o.status = status;
            o.last = (n == 8);
            coef_expected.push_back(o);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("error at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                    items_sent <= items_sent + 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cam_out_t want;
        if (aresetn && s_valid && s_ready) predict_matrix(s_data);
        if (aresetn && m_valid && m_ready) begin
            coefs_seen++;
            if (coef_expected.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(m_data), 64'd0);
            end else begin
                want = coef_expected.pop_front();
                if (m_data.entry_row !== want.entry_row)
                    report_mismatch("entry_row", 64'(m_data.entry_row), 64'(want.entry_row));
                if (m_data.entry_col !== want.entry_col)
                    report_mismatch("entry_col", 64'(m_data.entry_col), 64'(want.entry_col));
                if (m_data.coefficient !== want.coefficient)
                    report_mismatch("coefficient", 64'(m_data.coefficient),
                                    64'(want.coefficient));
                if (m_data.saturated !== want.saturated)
                    report_mismatch("saturated", 64'(m_data.saturated), 64'(want.saturated));
                if (m_data.status !== want.status)
                    report_mismatch("status", 64'(m_data.status), 64'(want.status));
                if (m_data.last !== want.last)
                    report_mismatch("last", 64'(m_data.last), 64'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic cam_in_t make_item(adapt_mode_e md, logic [23:0] sl, logic [15:0] sx,
                                          logic [15:0] sy, logic [23:0] dl, logic [15:0] dx,
                                          logic [15:0] dy);
        cam_in_t it;
        it.adapt_mode = md;
        it.src_lum = sl;
        it.src_cx = sx;
        it.src_cy = sy;
        it.dst_lum = dl;
        it.dst_cx = dx;
        it.dst_cy = dy;
        return it;
    endfunction

    function automatic cam_in_t random_item();
        cam_in_t it;
        it = cam_in_t'({$urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                it.src_cx = 16'($urandom_range(14000, 31000));
                it.src_cy = 16'($urandom_range(15000, 29000));
                it.dst_cx = 16'($urandom_range(14000, 31000));
                it.dst_cy = 16'($urandom_range(15000, 29000));
                it.src_lum = 24'($urandom_range(1, 24'hffffff));
                it.dst_lum = 24'($urandom_range(0, 24'hffffff));
            end
            6: it.dst_lum = 24'($urandom_range(0, 3));
            7: it.src_lum = 24'($urandom_range(1, 16));
            default: ;
        endcase
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || coef_expected.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    initial begin
        int phase_pct[4][2];
        phase_pct = '{'{0, 0}, '{58, 0}, '{0, 58}, '{22, 22}};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int md = 0; md < 4; md++) begin
            pending_items.push_back(make_item(adapt_mode_e'(md), 24'h010000, 16'd20557,
                                              16'd21627, 24'h010000, 16'd22971, 16'd23569));
        end
        pending_items.push_back(make_item(MODE_BRADFORD, 24'h0, 16'd20557, 16'd21627,
                                          24'h010000, 16'd22971, 16'd23569));
        pending_items.push_back(make_item(MODE_NONE, 24'h0, 16'd0, 16'd0, 24'h5, 16'd0, 16'd0));
        pending_items.push_back(make_item(MODE_NONE, 24'h1, 16'd0, 16'd0, 24'hffffff,
                                          16'hffff, 16'hffff));
        pending_items.push_back(make_item(MODE_NONE, 24'hffffff, 16'hffff, 16'hffff,
                                          24'h1, 16'd0, 16'd0));
        pending_items.push_back(make_item(MODE_XYZ, 24'h010000, 16'd20557, 16'd0,
                                          24'h010000, 16'd22971, 16'd23569));
        pending_items.push_back(make_item(MODE_VON_KRIES, 24'h010000, 16'd20557, 16'd21627,
                                          24'h010000, 16'd22971, 16'd0));
        pending_items.push_back(make_item(MODE_XYZ, 24'h010000, 16'd0, 16'd65535,
                                          24'h010000, 16'd22971, 16'd23569));
        pending_items.push_back(make_item(MODE_BRADFORD, 24'h010000, 16'd20557, 16'd21627,
                                          24'h0, 16'd22971, 16'd23569));
        pending_items.push_back(make_item(MODE_BRADFORD, 24'h010000, 16'd40000, 16'd40000,
                                          24'h020000, 16'd50000, 16'd30000));
        pending_items.push_back(make_item(MODE_XYZ, 24'h1, 16'd20557, 16'd21627,
                                          24'hffffff, 16'd22971, 16'd23569));
        pending_items.push_back(make_item(MODE_VON_KRIES, 24'hffffff, 16'hffff, 16'h1,
                                          24'hffffff, 16'hffff, 16'hffff));
        pending_items.push_back(make_item(MODE_BRADFORD, 24'h1, 16'd1, 16'hffff,
                                          24'hffffff, 16'hffff, 16'd1));
        pending_items.push_back(make_item(MODE_XYZ, 24'hffffff, 16'hffff, 16'hffff,
                                          24'hffffff, 16'hffff, 16'hffff));
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_pct[p][0];
            recv_stall_pct = phase_pct[p][1];
            for (int n = 0; n < 65; n++) pending_items.push_back(random_item());
            if (p == 1) begin
                while (pending_items.size() > 30 || s_valid) @(posedge aclk);
                hold_send = 1'b1;
                while (coef_expected.size() > 0) @(posedge aclk);
                hold_send = 1'b0;
            end
            wait_drained();
        end

        $display("covered %0d items and %0d coefficient transfers over four flow-control phases",
                 items_sent, coefs_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* sim.f */
sv/cam_pkg.sv
sv/cam_div.sv
sv/cam_front.sv
sv/cam_queue.sv
sv/cam_back.sv
sv/chromatic_adaptation_matrix_core.sv
verif/tb_chromatic_adaptation_matrix_core.sv
